FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk with asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define CPR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");

// Checks that a condition never holds outside reset.
`define CPR_NEVER(lbl, cond) \
	`CPR_ASSERT(lbl, !(cond))

`endif

FILE: rtl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Types and constants shared by the clock page replacement modules.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;

	localparam int CFG_W      = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam int PAGE_W     = 16;
	localparam int GIVEN_W    = 16;
	localparam int IDX_OUT_W  = 4;
	localparam int BITS_OUT_W = 16;
	localparam int TOTAL_W    = 32;

	localparam int S_TDATA_W  = PAGE_W + GIVEN_W;
	localparam int M_FIELDS_W = 2 * IDX_OUT_W + BITS_OUT_W + TOTAL_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_DECIDE,
		ST_SWEEP,
		ST_DONE
	} cpr_state_t;

	typedef struct packed {
		logic capture;
		logic compare;
		logic hit;
		logic fill;
		logic load_given;
		logic step;
		logic place;
		logic load_out;
	} cpr_cmd_t;

	typedef struct packed {
		logic hit;
		logic empty;
		logic hand_ref;
		logic out_free;
	} cpr_sts_t;

endpackage

FILE: rtl/cpr_ctrl.sv
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer for one page reference: lookup, decision, clock sweep, result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  cpr_pkg::cpr_sts_t sts,
	output cpr_pkg::cpr_cmd_t cmd
);
	import cpr_pkg::*;

	cpr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d     = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.hit) begin
					cmd.hit = 1'b1;
					state_d = ST_DONE;
				end else if (sts.empty) begin
					cmd.fill = 1'b1;
					state_d  = ST_DONE;
				end else begin
					cmd.load_given = 1'b1;
					state_d        = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sts.hand_ref) begin
					cmd.step = 1'b1;
				end else begin
					cmd.place = 1'b1;
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`CPR_ASSERT(a_accept_to_cmp, (s_tvalid && s_tready) |=> (state_q == ST_CMP))
	`CPR_ASSERT(a_sweep_from_decide,
		(state_q == ST_SWEEP) |-> ($past(state_q) == ST_DECIDE || $past(state_q) == ST_SWEEP))

endmodule

FILE: rtl/cpr_datapath.sv
// ----------------------------------------------------------------------------
// cpr_datapath
// Frame table, reference bits, clock hand, fault counter and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpr_datapath #(
	parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cpr_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [cpr_pkg::PAGE_W-1:0]    page_number,
	input  logic [cpr_pkg::GIVEN_W-1:0]   given_ref_bits,
	input  cpr_pkg::cpr_cmd_t             cmd,
	output cpr_pkg::cpr_sts_t             sts,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic                          fault,
	output logic [cpr_pkg::IDX_OUT_W-1:0] frame_index,
	output logic [cpr_pkg::IDX_OUT_W-1:0] hand_position,
	output logic [cpr_pkg::BITS_OUT_W-1:0] ref_bits_now,
	output logic [cpr_pkg::TOTAL_W-1:0]   fault_total
);
	import cpr_pkg::*;

	localparam int HW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW = $clog2(FRAMES + 1);

	logic [CFG_W-1:0]     cfg_q;
	logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
	logic [FRAMES-1:0]    valid_q;
	logic [FRAMES-1:0]    ref_q;
	logic [HW-1:0]        hand_q;
	logic [TOTAL_W-1:0]   fault_count_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [GIVEN_W-1:0]   given_q;
	logic [FRAMES-1:0]    match_q;
	logic [FRAMES-1:0]    empty_q;
	logic                 fault_q;
	logic [HW-1:0]        slot_q;
	logic                 out_valid_q;

	logic [7:0]                   cfg_ext;
	logic [NW-1:0]                n;
	logic [FRAMES-1:0]            managed;
	logic [PAGE_W+PAGE_BITS-1:0]  page_ext;
	logic [HW-1:0]                match_idx;
	logic [HW-1:0]                empty_idx;
	logic [HW-1:0]                hand_next;
	logic [HW-1:0]                hand_start;
	logic [FRAMES+GIVEN_W-1:0]    given_ext;
	logic [FRAMES+BITS_OUT_W-1:0] bits_ext;
	logic [HW+IDX_OUT_W-1:0]      slot_ext;
	logic [HW+IDX_OUT_W-1:0]      hand_ext;

	always_comb begin
		cfg_ext = {{(8 - CFG_W){1'b0}}, cfg_q};
		if (cfg_ext == 8'd0) begin
			n = NW'(1);
		end else if (cfg_ext > 8'(FRAMES)) begin
			n = NW'(FRAMES);
		end else begin
			n = NW'(cfg_ext);
		end
		for (int i = 0; i < FRAMES; i++) begin
			managed[i] = (NW'(i) < n);
		end
	end

	assign page_ext = {{PAGE_BITS{1'b0}}, page_number};

	always_comb begin
		match_idx = '0;
		empty_idx = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				match_idx = HW'(i);
			end
			if (empty_q[i]) begin
				empty_idx = HW'(i);
			end
		end
	end

	assign hand_next  = (NW'(hand_q) == n - NW'(1)) ? '0 : hand_q + HW'(1);
	assign hand_start = (NW'(hand_q) >= n) ? '0 : hand_q;
	assign given_ext  = {{FRAMES{1'b0}}, given_q};

	assign sts.hit      = |match_q;
	assign sts.empty    = |empty_q;
	assign sts.hand_ref = ref_q[hand_q];
	assign sts.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q         <= CFG_RESET;
			valid_q       <= '0;
			ref_q         <= '0;
			hand_q        <= '0;
			fault_count_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if ((cmd.fill || cmd.load_given) && fault_count_q != '1) begin
				fault_count_q <= fault_count_q + TOTAL_W'(1);
			end
			if (cmd.hit) begin
				ref_q[match_idx] <= 1'b1;
			end
			if (cmd.fill) begin
				valid_q[empty_idx] <= 1'b1;
				ref_q[empty_idx]   <= 1'b1;
			end
			if (cmd.load_given) begin
				for (int i = 0; i < FRAMES; i++) begin
					if (managed[i]) begin
						ref_q[i] <= given_ext[i];
					end
				end
				hand_q <= hand_start;
			end
			if (cmd.step) begin
				ref_q[hand_q] <= 1'b0;
				hand_q        <= hand_next;
			end
			if (cmd.place) begin
				valid_q[hand_q] <= 1'b1;
				ref_q[hand_q]   <= 1'b1;
				hand_q          <= hand_next;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			page_q  <= page_ext[PAGE_BITS-1:0];
			given_q <= given_ref_bits;
		end
		if (cmd.compare) begin
			for (int i = 0; i < FRAMES; i++) begin
				match_q[i] <= valid_q[i] && managed[i] && (frame_page_q[i] == page_q);
				empty_q[i] <= !valid_q[i] && managed[i];
			end
		end
		if (cmd.hit) begin
			fault_q <= 1'b0;
			slot_q  <= match_idx;
		end
		if (cmd.fill) begin
			fault_q                 <= 1'b1;
			slot_q                  <= empty_idx;
			frame_page_q[empty_idx] <= page_q;
		end
		if (cmd.load_given) begin
			fault_q <= 1'b1;
		end
		if (cmd.place) begin
			slot_q               <= hand_q;
			frame_page_q[hand_q] <= page_q;
		end
		if (cmd.load_out) begin
			fault         <= fault_q;
			frame_index   <= slot_ext[IDX_OUT_W-1:0];
			hand_position <= hand_ext[IDX_OUT_W-1:0];
			ref_bits_now  <= bits_ext[BITS_OUT_W-1:0];
			fault_total   <= fault_count_q;
		end
	end

	assign slot_ext = {{IDX_OUT_W{1'b0}}, slot_q};
	assign hand_ext = {{IDX_OUT_W{1'b0}}, hand_q};
	assign bits_ext = {{BITS_OUT_W{1'b0}}, ref_q & managed};
	assign m_tvalid = out_valid_q;

	`CPR_ASSERT(a_step_needs_ref, cmd.step |-> ref_q[hand_q])
	`CPR_ASSERT(a_count_monotonic, fault_count_q >= $past(fault_count_q))
	`CPR_ASSERT(a_hand_in_range, cmd.place |=> (NW'(hand_q) < n))
	`CPR_NEVER(a_load_while_busy, cmd.load_out && out_valid_q && !m_tready)

endmodule

FILE: rtl/clock_page_replacement_top.sv
// ----------------------------------------------------------------------------
// clock_page_replacement_top
// Clock (second-chance) page replacement over up to FRAMES page frames.
// ----------------------------------------------------------------------------
// One page reference is handled at a time. A hit or a fill of an empty frame
// goes from lookup and decision straight to the result. A fault with all
// managed frames full first loads the given reference bits, then the clock
// hand clears set reference bits, one frame per cycle in the sweep, until it
// finds a clear one to replace. A finished result sits in an output register,
// so the next transaction can be accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module clock_page_replacement_top #(
	parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cpr_pkg::CFG_W-1:0]     cfg_wdata,      // frames_in_use
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cpr_pkg::S_TDATA_W-1:0] s_tdata,        // page_number, given_ref_bits
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cpr_pkg::M_TDATA_W-1:0] m_tdata,        // frame_index, hand_position,
	                                                      // ref_bits_now, fault_total
	output logic                          m_tuser         // fault
);
	import cpr_pkg::*;

	cpr_cmd_t               cmd;
	cpr_sts_t               sts;
	logic                   fault;
	logic [IDX_OUT_W-1:0]   frame_index;
	logic [IDX_OUT_W-1:0]   hand_position;
	logic [BITS_OUT_W-1:0]  ref_bits_now;
	logic [TOTAL_W-1:0]     fault_total;

	cpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpr_datapath #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.page_number    (s_tdata[PAGE_W-1:0]),
		.given_ref_bits (s_tdata[PAGE_W+GIVEN_W-1:PAGE_W]),
		.cmd            (cmd),
		.sts            (sts),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.fault          (fault),
		.frame_index    (frame_index),
		.hand_position  (hand_position),
		.ref_bits_now   (ref_bits_now),
		.fault_total    (fault_total)
	);

	assign m_tuser = fault;
	assign m_tdata = M_TDATA_W'({fault_total, ref_bits_now, hand_position, frame_index});

endmodule

FILE: dv/clock_page_replacement_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_page_replacement_top_test
// Self-checking bench for the clock page replacement block. Page references
// are streamed in while a local second-chance predictor tracks the frames,
// the reference bits, the hand and the fault count. Every result transaction
// is checked field by field against the oldest prediction. The frame count is
// changed between phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module clock_page_replacement_top_test;

	import cpr_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 30;

	typedef struct packed {
		logic                  fault;
		logic [IDX_OUT_W-1:0]  frame_index;
		logic [IDX_OUT_W-1:0]  hand_position;
		logic [BITS_OUT_W-1:0] ref_bits_now;
		logic [TOTAL_W-1:0]    fault_total;
	} ref_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;

	// Predicted state of the page frames.
	logic [PAGE_W-1:0]     frame_page [16];
	logic [15:0]           frame_valid;
	logic [15:0]           ref_bit;
	int                    hand;
	logic [TOTAL_W-1:0]    fault_count;
	logic [CFG_W-1:0]      frames_in_use;

	ref_result_t           pending_results [$];
	int                    mismatch_count;
	bit                    steady;
	bit                    hold_req;
	int                    quiet_cycles;

	clock_page_replacement_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic ref_result_t clock_lookup(input logic [PAGE_W-1:0] page,
		input logic [GIVEN_W-1:0] given);
		ref_result_t r;
		int n;
		int slot;
		int i;
		bit found;
		bit empty;
		logic [16:0] mask;
		n = frames_in_use;
		if (n < 1) n = 1;
		if (n > 16) n = 16;
		found = 1'b0;
		empty = 1'b0;
		slot = 0;
		for (i = 0; i < n; i++) begin
			if (!found && frame_valid[i] && frame_page[i] == page) begin
				found = 1'b1;
				slot = i;
			end
		end
		if (found) begin
			ref_bit[slot] = 1'b1;
		end else begin
			if (fault_count != '1) fault_count++;
			for (i = 0; i < n; i++) begin
				if (!empty && !frame_valid[i]) begin
					empty = 1'b1;
					slot = i;
				end
			end
			if (empty) begin
				frame_valid[slot] = 1'b1;
				frame_page[slot] = page;
				ref_bit[slot] = 1'b1;
			end else begin
				for (i = 0; i < n; i++) ref_bit[i] = given[i];
				if (hand >= n) hand = 0;
				for (i = 0; i <= n; i++) begin
					if (!ref_bit[hand]) break;
					ref_bit[hand] = 1'b0;
					hand = (hand + 1) % n;
				end
				slot = hand;
				frame_page[slot] = page;
				frame_valid[slot] = 1'b1;
				ref_bit[slot] = 1'b1;
				hand = (hand + 1) % n;
			end
		end
		mask = (17'd1 << n) - 17'd1;
		r.fault = !found;
		r.frame_index = 4'(slot);
		r.hand_position = 4'(hand);
		r.ref_bits_now = ref_bit & mask[15:0];
		r.fault_total = fault_count;
		return r;
	endfunction

	task automatic send_reference(input logic [PAGE_W-1:0] page,
		input logic [GIVEN_W-1:0] given);
		while (!steady && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {given, page};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results = {pending_results, clock_lookup(page, given)};
	endtask

	task automatic write_frame_count(input logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		frames_in_use = value;
	endtask

	task automatic test_fill_and_hit;
		send_reference(16'h0000, 16'hFFFF);
		send_reference(16'hFFFF, 16'h0000);
		send_reference(16'h0000, 16'h5A5A);
		send_reference(16'hFFFF, 16'hA5A5);
	endtask

	task automatic test_clock_sweep;
		write_frame_count(5'd4);
		send_reference(16'h1234, 16'h0000);
		send_reference(16'h8421, 16'h0000);
		// All frames full: every bit set makes the hand go all the way round.
		send_reference(16'h4321, 16'hFFFF);
		send_reference(16'h7777, 16'h0000);
		send_reference(16'hBEEF, 16'h0005);
		send_reference(16'h4321, 16'h0000);
		send_reference(16'hC3C3, 16'h000A);
	endtask

	task automatic test_frame_count;
		// The hand may now sit beyond the two managed frames.
		write_frame_count(5'd2);
		send_reference(16'h0F0F, 16'h0003);
		write_frame_count(5'd0);
		send_reference(16'hFFFF, 16'h0001);
		send_reference(16'h2222, 16'h0000);
		// Raising the count again exposes an older copy of page 1234 left in a frame.
		write_frame_count(5'd31);
		send_reference(16'h2222, 16'h0000);
		send_reference(16'h1234, 16'h0000);
		send_reference(16'h3C3C, 16'h0000);
		write_frame_count(5'd17);
		send_reference(16'h0F0F, 16'h0000);
	endtask

	task automatic test_random_traffic;
		logic [CFG_W-1:0] settings [9] = '{5'd16, 5'd1, 5'd8, 5'd31, 5'd3,
			5'd17, 5'd0, 5'd12, 5'd16};
		logic [PAGE_W-1:0] base;
		logic [PAGE_W-1:0] page;
		logic [GIVEN_W-1:0] given;
		int n;
		int k;
		int j;
		for (k = 0; k < 9; k++) begin
			write_frame_count(settings[k]);
			n = settings[k];
			if (n < 1) n = 1;
			if (n > 16) n = 16;
			base = 16'($urandom_range(0, 65000));
			steady = (k == 4);
			for (j = 0; j < 72; j++) begin
				case ($urandom_range(9))
					0: page = 16'($urandom);
					default: page = base + 16'($urandom_range(0, n + n / 2 + 1));
				endcase
				case ($urandom_range(4))
					0: given = 16'h0000;
					1: given = 16'hFFFF;
					2: given = 16'($urandom) & 16'($urandom);
					default: given = 16'($urandom);
				endcase
				send_reference(page, given);
			end
			steady = 1'b0;
		end
	endtask

	task automatic test_output_stall;
		int j;
		hold_req = 1'b1;
		for (j = 0; j < 30; j++)
			send_reference(16'h0100 + 16'($urandom_range(0, 20)), 16'($urandom));
		s_tvalid <= 1'b0;
		do @(posedge clk); while (hold_req);
	endtask

	// Receiver side: random stalls, or one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 23);
			end
		end
	end

	always @(posedge clk) begin
		ref_result_t want;
		ref_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.fault = m_tuser;
			got.frame_index = m_tdata[3:0];
			got.hand_position = m_tdata[7:4];
			got.ref_bits_now = m_tdata[23:8];
			got.fault_total = m_tdata[55:24];
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result transaction, got %p", $realtime, got);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch, expected %p, got %p", $realtime, want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		steady = 1'b0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		mismatch_count = 0;
		frame_valid = '0;
		ref_bit = '0;
		hand = 0;
		fault_count = '0;
		frames_in_use = CFG_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_and_hit();
		test_clock_sweep();
		test_frame_count();
		test_random_traffic();
		test_output_stall();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cpr_pkg.sv
rtl/cpr_ctrl.sv
rtl/cpr_datapath.sv
rtl/clock_page_replacement_top.sv
dv/clock_page_replacement_top_test.sv
